// ===== src/vshc_pkg.sv =====
package vshc_pkg;

  localparam int NbWidth    = 54;
  localparam int KindWidth  = 3;
  localparam int HintWidth  = 8;
  localparam int CellCount  = 27;
  localparam int InDataWidth  = 64;
  localparam int OutDataWidth = 8;

  localparam logic [KindWidth-1:0] KIND_EMPTY   = 3'd0;
  localparam logic [KindWidth-1:0] KIND_UNKNOWN = 3'd1;
  localparam logic [KindWidth-1:0] KIND_LIQUID  = 3'd2;
  localparam logic [KindWidth-1:0] KIND_ROUNDED = 3'd3;
  localparam logic [KindWidth-1:0] KIND_SLOPED  = 3'd4;
  localparam logic [KindWidth-1:0] KIND_CUBE    = 3'd5;

  localparam logic [1:0] CLASS_SLOPED = 2'd2;

  localparam logic [HintWidth-1:0] HB_FACEUP   = 8'h01;
  localparam logic [HintWidth-1:0] HB_FACEDOWN = 8'h02;
  localparam logic [HintWidth-1:0] HB_SPECIAL1 = 8'h40;
  localparam logic [HintWidth-1:0] HB_SPECIAL2 = 8'h80;
  localparam int CornerShift = 2;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_PASS,
    MODE_SLOPE
  } mode_t;

  typedef struct packed {
    logic [CellCount-1:0] opn;
    logic [CellCount-1:0] slp;
    mode_t                mode;
    logic [HintWidth-1:0] prior;
  } cells_t;

  typedef struct packed {
    logic [3:0]           corners;
    logic                 amb;
    logic                 face_up;
    logic                 sp1;
    logic                 sp2;
    mode_t                mode;
    logic [HintWidth-1:0] prior;
  } corners_t;

  function automatic logic [4:0] cidx(input int x, input int y, input int z);
    return 5'(x + 3 * y + 9 * z);
  endfunction

endpackage

// ===== src/voxel_slope_hint_classifier_top.sv =====
// Channel | Direction | Ports                              | Beat
// s       | in        | s_tvalid s_tready s_tdata s_tuser  | one voxel
// m       | out       | m_tvalid m_tready m_tdata          | one hint byte
//
// Three register stages: cell decode, corner rules, hint compose.
// A beat is taken every cycle while m_tready is high; each stage registers it in turn.
// Reset clears the stage valid bits only; the stage data registers are not reset.
// A stalled stage holds its beat, and an empty stage still takes a new one.
module voxel_slope_hint_classifier_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [53:0] neighbour_classes, [61:54] prior_hint, [63:62] zero
  input  logic [vshc_pkg::InDataWidth-1:0]   s_tdata,
  // [2:0] centre_kind
  input  logic [vshc_pkg::KindWidth-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [7:0] hint
  output logic [vshc_pkg::OutDataWidth-1:0]  m_tdata
);

  logic               dec_valid;
  logic               dec_ready;
  vshc_pkg::cells_t   dec_data;
  logic               cor_valid;
  logic               cor_ready;
  vshc_pkg::corners_t cor_data;

  vshc_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .nb        (s_tdata[vshc_pkg::NbWidth-1:0]),
    .kind      (s_tuser),
    .prior     (s_tdata[vshc_pkg::NbWidth +: vshc_pkg::HintWidth]),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec_data)
  );

  vshc_corners u_corners (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (cor_valid),
    .out_ready (cor_ready),
    .out_data  (cor_data)
  );

  vshc_compose u_compose (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cor_valid),
    .in_ready  (cor_ready),
    .in_data   (cor_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .hint      (m_tdata)
  );

endmodule

// ===== src/vshc_decode.sv =====
module vshc_decode (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [vshc_pkg::NbWidth-1:0]    nb,
  input  logic [vshc_pkg::KindWidth-1:0]  kind,
  input  logic [vshc_pkg::HintWidth-1:0]  prior,
  output logic                            out_valid,
  input  logic                            out_ready,
  output vshc_pkg::cells_t                out_data
);

  vshc_pkg::cells_t cells_next;

  always_comb begin
    for (int i = 0; i < vshc_pkg::CellCount; i++) begin
      cells_next.opn[i] = ~nb[2*i+1];
      cells_next.slp[i] = (nb[2*i +: 2] == vshc_pkg::CLASS_SLOPED);
    end
    unique case (kind)
      vshc_pkg::KIND_EMPTY, vshc_pkg::KIND_LIQUID, vshc_pkg::KIND_ROUNDED: begin
        cells_next.mode = vshc_pkg::MODE_ZERO;
      end
      vshc_pkg::KIND_SLOPED: begin
        cells_next.mode = vshc_pkg::MODE_SLOPE;
      end
      default: begin
        cells_next.mode = vshc_pkg::MODE_PASS;
      end
    endcase
    cells_next.prior = prior;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= cells_next;
    end
  end

endmodule

// ===== src/vshc_corners.sv =====
module vshc_corners (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vshc_pkg::cells_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vshc_pkg::corners_t  out_data
);

  vshc_pkg::corners_t res_next;
  logic down;
  logic up;
  logic o010, o011, o012, o110, o112, o210, o211, o212;
  logic o100, o102, o001, o201;
  logic s110, s112, s011, s211;
  logic oy10, oy12, oy01, oy21;
  logic oz10, oz12, oz01, oz21;
  logic w00, w01, e10, e11, n00, n10, t01, t11;

  assign down = in_data.opn[vshc_pkg::cidx(1, 0, 1)];
  assign up   = in_data.opn[vshc_pkg::cidx(1, 2, 1)];

  assign o010 = in_data.opn[vshc_pkg::cidx(0, 1, 0)];
  assign o011 = in_data.opn[vshc_pkg::cidx(0, 1, 1)];
  assign o012 = in_data.opn[vshc_pkg::cidx(0, 1, 2)];
  assign o110 = in_data.opn[vshc_pkg::cidx(1, 1, 0)];
  assign o112 = in_data.opn[vshc_pkg::cidx(1, 1, 2)];
  assign o210 = in_data.opn[vshc_pkg::cidx(2, 1, 0)];
  assign o211 = in_data.opn[vshc_pkg::cidx(2, 1, 1)];
  assign o212 = in_data.opn[vshc_pkg::cidx(2, 1, 2)];
  assign o100 = in_data.opn[vshc_pkg::cidx(1, 0, 0)];
  assign o102 = in_data.opn[vshc_pkg::cidx(1, 0, 2)];
  assign o001 = in_data.opn[vshc_pkg::cidx(0, 0, 1)];
  assign o201 = in_data.opn[vshc_pkg::cidx(2, 0, 1)];

  assign s110 = in_data.slp[vshc_pkg::cidx(1, 1, 0)];
  assign s112 = in_data.slp[vshc_pkg::cidx(1, 1, 2)];
  assign s011 = in_data.slp[vshc_pkg::cidx(0, 1, 1)];
  assign s211 = in_data.slp[vshc_pkg::cidx(2, 1, 1)];

  // The open side of the center selects which layer counts as "toward" the slope.
  assign oy10 = down ? in_data.opn[vshc_pkg::cidx(1, 0, 0)] : in_data.opn[vshc_pkg::cidx(1, 2, 0)];
  assign oy12 = down ? in_data.opn[vshc_pkg::cidx(1, 0, 2)] : in_data.opn[vshc_pkg::cidx(1, 2, 2)];
  assign oy01 = down ? in_data.opn[vshc_pkg::cidx(0, 0, 1)] : in_data.opn[vshc_pkg::cidx(0, 2, 1)];
  assign oy21 = down ? in_data.opn[vshc_pkg::cidx(2, 0, 1)] : in_data.opn[vshc_pkg::cidx(2, 2, 1)];
  assign oz10 = down ? in_data.opn[vshc_pkg::cidx(1, 2, 0)] : in_data.opn[vshc_pkg::cidx(1, 0, 0)];
  assign oz12 = down ? in_data.opn[vshc_pkg::cidx(1, 2, 2)] : in_data.opn[vshc_pkg::cidx(1, 0, 2)];
  assign oz01 = down ? in_data.opn[vshc_pkg::cidx(0, 2, 1)] : in_data.opn[vshc_pkg::cidx(0, 0, 1)];
  assign oz21 = down ? in_data.opn[vshc_pkg::cidx(2, 2, 1)] : in_data.opn[vshc_pkg::cidx(2, 0, 1)];

  assign w00 = o010 & o011 & s110 & oy10 & !oz10 & !o210 & !o211;
  assign w01 = o012 & o011 & s112 & oy12 & !oz12 & !o212 & !o211;
  assign e10 = o210 & o211 & s110 & oy10 & !oz10 & !o010 & !o011;
  assign e11 = o212 & o211 & s112 & oy12 & !oz12 & !o012 & !o011;
  assign n00 = o110 & o010 & s011 & oy01 & !oz01 & !o112 & !o012;
  assign n10 = o110 & o210 & s211 & oy21 & !oz21 & !o112 & !o212;
  assign t01 = o112 & o012 & s011 & oy01 & !oz01 & !o110 & !o010;
  assign t11 = o112 & o212 & s211 & oy21 & !oz21 & !o110 & !o210;

  always_comb begin
    res_next.corners[0] = (o011 & o110) | w00 | n00;
    res_next.corners[1] = (o211 & o110) | e10 | n10;
    res_next.corners[2] = (o011 & o112) | w01 | t01;
    res_next.corners[3] = (o211 & o112) | e11 | t11;
    res_next.amb        = (down == up);
    res_next.face_up    = !down;
    res_next.sp1        = o100 & o102;
    res_next.sp2        = o001 & o201;
    res_next.mode       = in_data.mode;
    res_next.prior      = in_data.prior;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= res_next;
    end
  end

endmodule

// ===== src/vshc_compose.sv =====
module vshc_compose (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  vshc_pkg::corners_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [vshc_pkg::HintWidth-1:0] hint
);

  logic [vshc_pkg::HintWidth-1:0] hint_next;
  logic [vshc_pkg::HintWidth-1:0] face;

  assign face = in_data.face_up ? vshc_pkg::HB_FACEUP : vshc_pkg::HB_FACEDOWN;

  always_comb begin
    unique case (in_data.mode)
      vshc_pkg::MODE_PASS: begin
        hint_next = in_data.prior;
      end
      vshc_pkg::MODE_SLOPE: begin
        priority if (in_data.amb) begin
          hint_next = '0;
        end else if (&in_data.corners) begin
          priority if (in_data.sp1) begin
            hint_next = face | vshc_pkg::HB_SPECIAL1;
          end else if (in_data.sp2) begin
            hint_next = face | vshc_pkg::HB_SPECIAL2;
          end else begin
            hint_next = face;
          end
        end else begin
          hint_next = face | (vshc_pkg::HintWidth'(in_data.corners) << vshc_pkg::CornerShift);
        end
      end
      default: begin
        hint_next = '0;
      end
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hint <= hint_next;
    end
  end

endmodule

// ===== test/tb_voxel_slope_hint_classifier_top.sv =====
`timescale 1ns / 1ps

module tb_voxel_slope_hint_classifier_top;
  import vshc_pkg::*;

  localparam logic [1:0] CLS_EMPTY  = 2'd0;
  localparam logic [1:0] CLS_LIQUID = 2'd1;
  localparam logic [1:0] CLS_SOLID  = 2'd3;

  localparam logic [KindWidth-1:0] KIND_UNDEF6 = 3'd6;
  localparam logic [KindWidth-1:0] KIND_UNDEF7 = 3'd7;

  localparam logic [NbWidth-1:0] ALL_EMPTY = '0;
  localparam logic [NbWidth-1:0] ALL_SOLID = '1;

  localparam int RandomVoxels = 1250;
  localparam int CycleLimit   = 300000;

  class hint_scoreboard;
    logic [HintWidth-1:0] hint_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function logic [1:0] class_at(logic [NbWidth-1:0] nb, int x, int y, int z);
      return nb[2*(x+3*y+9*z) +: 2];
    endfunction

    function bit is_open(logic [NbWidth-1:0] nb, int x, int y, int z);
      return class_at(nb, x, y, z) <= CLS_LIQUID;
    endfunction

    function bit is_slope(logic [NbWidth-1:0] nb, int x, int y, int z);
      return class_at(nb, x, y, z) == CLASS_SLOPED;
    endfunction

    // A slope that runs on from the face neighbour at (1,1,z), open toward side xs.
    function bit runs_along_x(logic [NbWidth-1:0] nb, int z, int xs, int y, int y1);
      return is_open(nb, xs, 1, z) && is_open(nb, xs, 1, 1) && is_slope(nb, 1, 1, z) &&
             is_open(nb, 1, y, z) && !is_open(nb, 1, y1, z) &&
             !is_open(nb, 2-xs, 1, z) && !is_open(nb, 2-xs, 1, 1);
    endfunction

    // A slope that runs on from the face neighbour at (x,1,1), open toward side z.
    function bit runs_along_z(logic [NbWidth-1:0] nb, int x, int z, int y, int y1);
      return is_open(nb, 1, 1, z) && is_open(nb, x, 1, z) && is_slope(nb, x, 1, 1) &&
             is_open(nb, x, y, 1) && !is_open(nb, x, y1, 1) &&
             !is_open(nb, 1, 1, 2-z) && !is_open(nb, x, 1, 2-z);
    endfunction

    function logic [HintWidth-1:0] slope_hint(logic [NbWidth-1:0] nb);
      bit below_open;
      bit above_open;
      bit [3:0] corners;
      int y;
      int y1;
      int cx;
      int cz;
      logic [HintWidth-1:0] h;
      below_open = is_open(nb, 1, 0, 1);
      above_open = is_open(nb, 1, 2, 1);
      if (below_open == above_open) return '0;
      y  = below_open ? 0 : 2;
      y1 = 2 - y;
      for (int k = 0; k < 4; k++) begin
        cx = 2 * (k % 2);
        cz = 2 * (k / 2);
        corners[k] = (is_open(nb, cx, 1, 1) && is_open(nb, 1, 1, cz)) ||
                     runs_along_x(nb, cz, cx, y, y1) || runs_along_z(nb, cx, cz, y, y1);
      end
      h = (y == 2) ? HB_FACEUP : HB_FACEDOWN;
      if (&corners) begin
        if (is_open(nb, 1, 0, 0) && is_open(nb, 1, 0, 2)) begin
          h |= HB_SPECIAL1;
        end else if (is_open(nb, 0, 0, 1) && is_open(nb, 2, 0, 1)) begin
          h |= HB_SPECIAL2;
        end
      end else begin
        h |= HintWidth'(corners) << CornerShift;
      end
      return h;
    endfunction

    function logic [HintWidth-1:0] predict(logic [NbWidth-1:0] nb,
                                           logic [KindWidth-1:0] kind,
                                           logic [HintWidth-1:0] prior);
      case (kind)
        KIND_EMPTY, KIND_LIQUID, KIND_ROUNDED: return '0;
        KIND_SLOPED: return slope_hint(nb);
        default: return prior;
      endcase
    endfunction

    function void note_voxel(logic [NbWidth-1:0] nb, logic [KindWidth-1:0] kind,
                             logic [HintWidth-1:0] prior);
      hint_q.push_back(predict(nb, kind, prior));
    endfunction

    function void check_hint(logic [HintWidth-1:0] got);
      logic [HintWidth-1:0] want;
      if (hint_q.size() == 0) begin
        $error("hint: no beat expected, actual %02h", got);
        errors++;
      end else begin
        want = hint_q.pop_front();
        if (got !== want) begin
          $error("hint: expected %02h, actual %02h", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return hint_q.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [InDataWidth-1:0]  s_tdata = '0;
  logic [KindWidth-1:0]    s_tuser = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b1;
  logic [OutDataWidth-1:0] m_tdata;

  hint_scoreboard sb;
  bit gaps_on = 1'b1;
  int cycle_count = 0;

  voxel_slope_hint_classifier_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_voxel(s_tdata[NbWidth-1:0], s_tuser, s_tdata[NbWidth +: HintWidth]);
      end
      if (m_tvalid && m_tready) begin
        sb.check_hint(m_tdata);
      end
    end
  end

  initial begin
    @(negedge rst);
    forever begin
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic [NbWidth-1:0] put_cell(input logic [NbWidth-1:0] nb,
                                                  input int x, input int y, input int z,
                                                  input logic [1:0] c);
    logic [NbWidth-1:0] r;
    r = nb;
    r[2*(x+3*y+9*z) +: 2] = c;
    return r;
  endfunction

  function automatic logic [1:0] any_open();
    return 2'($urandom_range(0, 1));
  endfunction

  function automatic logic [1:0] any_solid();
    return 2'($urandom_range(2, 3));
  endfunction

  function automatic logic [NbWidth-1:0] rand_cells();
    return {22'($urandom), 32'($urandom)};
  endfunction

  // Plants the cells that let a sloped neighbour carry its slope into one corner.
  function automatic logic [NbWidth-1:0] plant_run(input logic [NbWidth-1:0] nb,
                                                   input int rule, input int y);
    logic [NbWidth-1:0] r;
    int a;
    int b;
    int y1;
    a  = (rule & 2) ? 2 : 0;
    b  = (rule & 1) ? 2 : 0;
    y1 = 2 - y;
    r  = nb;
    if (rule < 4) begin
      r = put_cell(r, b, 1, a, any_open());
      r = put_cell(r, b, 1, 1, any_open());
      r = put_cell(r, 1, 1, a, CLASS_SLOPED);
      r = put_cell(r, 1, y, a, any_open());
      r = put_cell(r, 1, y1, a, any_solid());
      r = put_cell(r, 2-b, 1, a, any_solid());
      r = put_cell(r, 2-b, 1, 1, any_solid());
    end else begin
      r = put_cell(r, 1, 1, b, any_open());
      r = put_cell(r, a, 1, b, any_open());
      r = put_cell(r, a, 1, 1, CLASS_SLOPED);
      r = put_cell(r, a, y, 1, any_open());
      r = put_cell(r, a, y1, 1, any_solid());
      r = put_cell(r, 1, 1, 2-b, any_solid());
      r = put_cell(r, a, 1, 2-b, any_solid());
    end
    return r;
  endfunction

  function automatic logic [NbWidth-1:0] shaped_slope_cells();
    logic [NbWidth-1:0] nb;
    bit below_open;
    int y;
    nb = rand_cells();
    below_open = 1'($urandom_range(0, 1));
    y = below_open ? 0 : 2;
    if ($urandom_range(0, 9) != 0) begin
      nb = put_cell(nb, 1, 0, 1, below_open ? any_open() : any_solid());
      nb = put_cell(nb, 1, 2, 1, below_open ? any_solid() : any_open());
    end
    case ($urandom_range(0, 3))
      0: begin
        nb = put_cell(nb, 0, 1, 1, any_open());
        nb = put_cell(nb, 2, 1, 1, any_open());
        nb = put_cell(nb, 1, 1, 0, any_open());
        nb = put_cell(nb, 1, 1, 2, any_open());
      end
      1: nb = plant_run(nb, $urandom_range(0, 7), y);
      2: nb = plant_run(plant_run(nb, $urandom_range(0, 7), y), $urandom_range(0, 7), y);
      default: ;
    endcase
    return nb;
  endfunction

  task automatic send_voxel(input logic [NbWidth-1:0] nb, input logic [KindWidth-1:0] kind,
                            input logic [HintWidth-1:0] prior);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InDataWidth-NbWidth-HintWidth){1'b0}}, prior, nb};
    s_tuser  <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_hints();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [NbWidth-1:0] nb;
    int pick;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_voxel(ALL_SOLID, KIND_EMPTY, 8'hFF);
    send_voxel(ALL_EMPTY, KIND_UNKNOWN, 8'h00);
    send_voxel(rand_cells(), KIND_UNKNOWN, 8'hFF);
    send_voxel(ALL_SOLID, KIND_LIQUID, 8'hFF);
    send_voxel(rand_cells(), KIND_ROUNDED, 8'hFF);
    send_voxel(rand_cells(), KIND_CUBE, 8'hA5);
    send_voxel(rand_cells(), KIND_UNDEF6, 8'h5A);
    send_voxel(ALL_SOLID, KIND_UNDEF7, 8'hFF);
    send_voxel(ALL_EMPTY, KIND_SLOPED, 8'hFF);
    send_voxel(ALL_SOLID, KIND_SLOPED, 8'hFF);
    nb = put_cell(ALL_EMPTY, 1, 2, 1, CLS_SOLID);
    send_voxel(nb, KIND_SLOPED, 8'hFF);
    send_voxel(put_cell(nb, 1, 1, 1, CLASS_SLOPED), KIND_SLOPED, 8'h00);
    send_voxel(put_cell(nb, 1, 1, 1, CLS_SOLID), KIND_SLOPED, 8'h00);
    send_voxel(put_cell(ALL_EMPTY, 1, 0, 1, CLS_SOLID), KIND_SLOPED, 8'h00);
    nb = put_cell(nb, 1, 0, 0, CLS_SOLID);
    send_voxel(nb, KIND_SLOPED, 8'h00);
    send_voxel(put_cell(nb, 0, 0, 1, CLS_SOLID), KIND_SLOPED, 8'h00);
    send_voxel(put_cell(ALL_SOLID, 1, 0, 1, CLS_LIQUID), KIND_SLOPED, 8'h00);
    for (int r = 0; r < 8; r++) begin
      send_voxel(plant_run(put_cell(ALL_SOLID, 1, 0, 1, CLS_EMPTY), r, 0), KIND_SLOPED,
                 8'($urandom));
    end
    send_voxel(plant_run(put_cell(ALL_SOLID, 1, 2, 1, CLS_LIQUID), 5, 2), KIND_SLOPED, 8'h00);
    drain_hints();

    for (int i = 0; i < RandomVoxels; i++) begin
      if (i == RandomVoxels / 2) drain_hints();
      if (i == RandomVoxels - 150) gaps_on = 1'b0;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        send_voxel(shaped_slope_cells(), KIND_SLOPED, 8'($urandom));
      end else if (pick < 7) begin
        send_voxel(rand_cells(), KIND_SLOPED, 8'($urandom));
      end else begin
        send_voxel(rand_cells(), 3'($urandom_range(0, 7)), 8'($urandom));
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
